// ===== design/hsv_pkg.sv =====
// Shared widths, stage-enable struct and fixed-point divide helper for the HSV to RGB unit.
package hsv_pkg;

   localparam int HUE_W  = 11;
   localparam int CHAN_W = 8;
   localparam int PROD_W = 2 * CHAN_W;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } hsv_stage_en_type;

   // floor(x / 255) for x below 255*256
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] sum;
      sum = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[PROD_W-1:CHAN_W]} + {{PROD_W{1'b0}}, 1'b1};
      return sum[PROD_W-1:CHAN_W];
   endfunction

endpackage

// ===== design/hsv_if.sv =====
// Valid/ready channel interfaces for HSV input words and RGB output words.
interface hsv_req_if;
   logic                        valid;
   logic                        ready;
   logic [hsv_pkg::HUE_W-1:0]   hue;
   logic [hsv_pkg::CHAN_W-1:0]  saturation;
   logic [hsv_pkg::CHAN_W-1:0]  value;

   modport source (output valid, hue, saturation, value, input ready);
   modport sink   (input valid, hue, saturation, value, output ready);
endinterface

interface hsv_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hsv_pkg::CHAN_W-1:0]  red;
   logic [hsv_pkg::CHAN_W-1:0]  green;
   logic [hsv_pkg::CHAN_W-1:0]  blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== design/hsv_core.sv =====
// Three-stage HSV to RGB datapath: scale factors, products, divide and sector select.
module hsv_core (
   input  logic                        clock,
   input  hsv_pkg::hsv_stage_en_type   en,
   input  logic [hsv_pkg::HUE_W-1:0]   hue,
   input  logic [hsv_pkg::CHAN_W-1:0]  saturation,
   input  logic [hsv_pkg::CHAN_W-1:0]  value,
   output logic [hsv_pkg::CHAN_W-1:0]  red,
   output logic [hsv_pkg::CHAN_W-1:0]  green,
   output logic [hsv_pkg::CHAN_W-1:0]  blue
);
   import hsv_pkg::*;

   localparam int SEC_W = HUE_W - CHAN_W;
   localparam logic [SEC_W-1:0] SECTOR_RED_YEL   = 3'd0;
   localparam logic [SEC_W-1:0] SECTOR_YEL_GRN   = 3'd1;
   localparam logic [SEC_W-1:0] SECTOR_GRN_CYN   = 3'd2;
   localparam logic [SEC_W-1:0] SECTOR_CYN_BLU   = 3'd3;
   localparam logic [SEC_W-1:0] SECTOR_BLU_MAG   = 3'd4;
   localparam logic [SEC_W-1:0] SECTOR_MAG_RED   = 3'd5;
   localparam logic [CHAN_W-1:0] FULL           = '1;
   localparam logic [PROD_W-1:0] ROUND_BIAS     = PROD_W'(127);

   // stage 1: scale factors
   logic [CHAN_W-1:0]  frac;
   logic [PROD_W-1:0]  sf_prod;
   logic [PROD_W:0]    sfc_prod;
   logic [CHAN_W:0]    frac_c;
   logic [CHAN_W-1:0]  kp_in, kq_in, kt_in;
   logic [CHAN_W-1:0]  kp_ff, kq_ff, kt_ff;
   logic [CHAN_W-1:0]  v1_ff;
   logic [SEC_W-1:0]   sec1_ff;
   logic               gray1_ff;

   // stage 2: rounded products
   logic [PROD_W-1:0]  xp_in, xq_in, xt_in;
   logic [PROD_W-1:0]  xp_ff, xq_ff, xt_ff;
   logic [CHAN_W-1:0]  v2_ff;
   logic [SEC_W-1:0]   sec2_ff;
   logic               gray2_ff;

   // stage 3: divide and select
   logic [CHAN_W-1:0]  p, q, t;
   logic [CHAN_W-1:0]  red_in, green_in, blue_in;
   logic [CHAN_W-1:0]  red_ff, green_ff, blue_ff;

   always_comb begin
      frac     = hue[CHAN_W-1:0];
      frac_c   = (CHAN_W+1)'(1 << CHAN_W) - {1'b0, frac};
      sf_prod  = PROD_W'(saturation) * PROD_W'(frac);
      sfc_prod = (PROD_W+1)'(saturation) * (PROD_W+1)'(frac_c);
      kp_in    = FULL - saturation;
      kq_in    = FULL - sf_prod[PROD_W-1:CHAN_W];
      kt_in    = FULL - sfc_prod[PROD_W-1:CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         kp_ff    <= kp_in;
         kq_ff    <= kq_in;
         kt_ff    <= kt_in;
         v1_ff    <= value;
         sec1_ff  <= hue[HUE_W-1:CHAN_W];
         gray1_ff <= (saturation == '0);
      end
   end

   always_comb begin
      xp_in = PROD_W'(v1_ff) * PROD_W'(kp_ff) + ROUND_BIAS;
      xq_in = PROD_W'(v1_ff) * PROD_W'(kq_ff) + ROUND_BIAS;
      xt_in = PROD_W'(v1_ff) * PROD_W'(kt_ff) + ROUND_BIAS;
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         xp_ff    <= xp_in;
         xq_ff    <= xq_in;
         xt_ff    <= xt_in;
         v2_ff    <= v1_ff;
         sec2_ff  <= sec1_ff;
         gray2_ff <= gray1_ff;
      end
   end

   always_comb begin
      p = div255(xp_ff);
      q = div255(xq_ff);
      t = div255(xt_ff);
      if (gray2_ff) begin
         red_in   = v2_ff;
         green_in = v2_ff;
         blue_in  = v2_ff;
      end else begin
         unique case (sec2_ff)
            SECTOR_RED_YEL: begin red_in = v2_ff; green_in = t;     blue_in = p;     end
            SECTOR_YEL_GRN: begin red_in = q;     green_in = v2_ff; blue_in = p;     end
            SECTOR_GRN_CYN: begin red_in = p;     green_in = v2_ff; blue_in = t;     end
            SECTOR_CYN_BLU: begin red_in = p;     green_in = q;     blue_in = v2_ff; end
            SECTOR_BLU_MAG: begin red_in = t;     green_in = p;     blue_in = v2_ff; end
            SECTOR_MAG_RED: begin red_in = v2_ff; green_in = p;     blue_in = q;     end
            default:        begin red_in = '0;    green_in = '0;    blue_in = '0;    end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red   = red_ff;
   assign green = green_ff;
   assign blue  = blue_ff;

endmodule

// ===== design/hsv_to_rgb_unit.sv =====
// HSV to RGB converter top level: pipeline flow control around the datapath.
//
//   channel      dir  word                       handshake
//   req_stream   in   hue, saturation, value     valid/ready
//   rsp_stream   out  red, green, blue           valid/ready
//
// One word per cycle sustained while the output is not stalled; a word passes the factor,
// product and divide/select registers in that order, the last one being the output register.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// collapse and a stall holds every full stage without loss or repeat.
// Synchronous reset clears the stage valid bits only.
module hsv_to_rgb_unit (
   input  logic             clock,
   input  logic             reset,
   hsv_req_if.sink          req_stream,
   hsv_rsp_if.source        rsp_stream
);
   import hsv_pkg::*;

   logic              vld1_ff, vld2_ff, vld3_ff;
   logic              vld1_in, vld2_in, vld3_in;
   logic              rdy1, rdy2, rdy3;
   hsv_stage_en_type  en;

   always_comb begin
      rdy3    = !vld3_ff || rsp_stream.ready;
      rdy2    = !vld2_ff || rdy3;
      rdy1    = !vld1_ff || rdy2;
      en.s1   = rdy1;
      en.s2   = rdy2;
      en.s3   = rdy3;
      vld1_in = rdy1 ? req_stream.valid : vld1_ff;
      vld2_in = rdy2 ? vld1_ff : vld2_ff;
      vld3_in = rdy3 ? vld2_ff : vld3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         vld1_ff <= vld1_in;
         vld2_ff <= vld2_in;
         vld3_ff <= vld3_in;
      end
   end

   assign req_stream.ready = rdy1;
   assign rsp_stream.valid = vld3_ff;

   hsv_core u_core (
      .clock      (clock),
      .en         (en),
      .hue        (req_stream.hue),
      .saturation (req_stream.saturation),
      .value      (req_stream.value),
      .red        (rsp_stream.red),
      .green      (rsp_stream.green),
      .blue       (rsp_stream.blue)
   );

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (vld1_ff && vld2_ff && vld3_ff && !rsp_stream.ready) |-> !req_stream.ready)
      else $error("input taken while pipeline full and stalled");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_stream.valid && req_stream.ready) |=> vld1_ff)
      else $error("accepted word missing from first stage");

   a_mid_holds: assert property (@(posedge clock) disable iff (reset)
      (vld2_ff && vld3_ff && !rsp_stream.ready) |=> (vld2_ff && vld3_ff))
      else $error("stalled word dropped from pipeline");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!vld1_ff && !vld2_ff && !vld3_ff))
      else $error("pipeline not empty after reset");

endmodule
